### hw/rtl/ffpa_pkg.sv
// ffpa_pkg: types, constants and state codes shared by the first-fit pool allocator
// used by ffpa_ctrl, ffpa_datapath and first_fit_pool_allocator; no dependencies
`default_nettype none

package ffpa_pkg;

  localparam int POOL_BYTES   = 1024;
  localparam int HEADER_BYTES = 32;
  localparam int MAX_ENTRIES  = 32;

  // field widths fixed by the interface
  localparam int SIZE_W  = 10;
  localparam int FIELD_W = 10;

  // internal offsets keep full pool precision, never narrower than the field
  localparam int OFF_W = ($clog2(POOL_BYTES) > FIELD_W) ? $clog2(POOL_BYTES) : FIELD_W;
  localparam int SUM_W = OFF_W + 2;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // request action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_ROOM = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] req_size;
    logic [FIELD_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] payload_offset;
  } res_t;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;          // latch request, restart the scan
    logic scan;          // advance the pipelined table walk
    logic commit_hit;    // apply matching entry and post ok
    logic fail_unknown;  // post free of unknown offset
    logic fail_room;     // post no room
    logic tail_rd;       // fetch last chunk for an append
    logic append;        // try the append and post its outcome
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic exhausted;
    logic is_free;
    logic table_full;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/ffpa_ctrl.sv
// ffpa_ctrl: sequencer for the first-fit pool allocator
// depends on ffpa_pkg (state_t, cmd_t, stat_t)
`default_nettype none

module ffpa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire ffpa_pkg::stat_t stat,
  output ffpa_pkg::cmd_t      cmd,
  output logic                busy
);

  ffpa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ffpa_pkg::ST_IDLE: begin
        // no transaction is taken while reset is held
        busy = rst;
        if (start && !rst) begin
          cmd.load   = 1'b1;
          state_next = ffpa_pkg::ST_SCAN;
        end
      end
      ffpa_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        priority if (stat.hit) begin
          cmd.commit_hit = 1'b1;
          state_next     = ffpa_pkg::ST_IDLE;
        end else if (stat.exhausted) begin
          priority if (stat.is_free) begin
            cmd.fail_unknown = 1'b1;
            state_next       = ffpa_pkg::ST_IDLE;
          end else if (stat.table_full) begin
            cmd.fail_room = 1'b1;
            state_next    = ffpa_pkg::ST_IDLE;
          end else begin
            cmd.tail_rd = 1'b1;
            state_next  = ffpa_pkg::ST_TAIL;
          end
        end
      end
      ffpa_pkg::ST_TAIL: begin
        cmd.append = 1'b1;
        state_next = ffpa_pkg::ST_IDLE;
      end
      default: begin
        state_next = ffpa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/ffpa_datapath.sv
// ffpa_datapath: chunk table memory, free flags, scan pipeline and result register
// depends on ffpa_pkg (entry_t, req_t, res_t, cmd_t, stat_t, constants)
`default_nettype none

module ffpa_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ffpa_pkg::req_t  req,
  input  wire ffpa_pkg::cmd_t  cmd,
  output ffpa_pkg::stat_t      stat,
  output logic                 done,
  output ffpa_pkg::res_t       result
);

  // chunk table: offset and size per entry, one write and one read port
  ffpa_pkg::entry_t mem [ffpa_pkg::MAX_ENTRIES];

  logic [ffpa_pkg::MAX_ENTRIES-1:0] entry_free;
  logic [ffpa_pkg::CNT_W-1:0]       entry_count;

  ffpa_pkg::req_t             op;
  logic [ffpa_pkg::CNT_W-1:0] rd_idx;
  logic [ffpa_pkg::IDX_W-1:0] cmp_idx;
  logic                       cmp_vld;
  logic                       tail_zero;
  ffpa_pkg::entry_t           rd_data;

  logic                       rd_en;
  logic [ffpa_pkg::IDX_W-1:0] rd_addr;
  logic                       wr_en;
  logic [ffpa_pkg::IDX_W-1:0] wr_addr;
  ffpa_pkg::entry_t           wr_data;

  logic                       match;
  logic [ffpa_pkg::SUM_W-1:0] payload;
  logic [ffpa_pkg::SUM_W-1:0] end_pos;
  logic                       append_ok;
  logic [ffpa_pkg::CNT_W-1:0] last_idx;

  assign last_idx = entry_count - ffpa_pkg::CNT_W'(1);

  assign match = cmp_vld && ((op.action == ffpa_pkg::ACT_FREE)
      ? (rd_data.off == ffpa_pkg::OFF_W'(op.free_offset))
      : (entry_free[cmp_idx] && (rd_data.size >= op.req_size)));

  assign stat.hit        = match;
  assign stat.exhausted  = (rd_idx == entry_count) && !cmp_vld;
  assign stat.is_free    = (op.action == ffpa_pkg::ACT_FREE);
  assign stat.table_full = (entry_count == ffpa_pkg::CNT_W'(ffpa_pkg::MAX_ENTRIES));

  // new chunk goes right after the last payload, or at byte 0 in an empty table
  assign payload = tail_zero ? ffpa_pkg::SUM_W'(ffpa_pkg::HEADER_BYTES)
                 : ffpa_pkg::SUM_W'(rd_data.off) + ffpa_pkg::SUM_W'(rd_data.size)
                   + ffpa_pkg::SUM_W'(ffpa_pkg::HEADER_BYTES);
  assign end_pos = payload + ffpa_pkg::SUM_W'(op.req_size);
  assign append_ok = (payload < ffpa_pkg::SUM_W'(ffpa_pkg::POOL_BYTES))
                  && (end_pos <= ffpa_pkg::SUM_W'(ffpa_pkg::POOL_BYTES));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_idx[ffpa_pkg::IDX_W-1:0];
    if (cmd.tail_rd) begin
      rd_en   = 1'b1;
      rd_addr = last_idx[ffpa_pkg::IDX_W-1:0];
    end else if (cmd.scan && (rd_idx < entry_count)) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_idx;
    wr_data = '{off: rd_data.off, size: op.req_size};
    if (cmd.commit_hit && (op.action == ffpa_pkg::ACT_ALLOC)) begin
      wr_en = 1'b1;
    end else if (cmd.append && append_ok) begin
      wr_en   = 1'b1;
      wr_addr = entry_count[ffpa_pkg::IDX_W-1:0];
      wr_data = '{off: payload[ffpa_pkg::OFF_W-1:0], size: op.req_size};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // request latch and scan pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req;
    end
    if (cmd.tail_rd) begin
      tail_zero <= (entry_count == '0);
    end
    cmp_idx <= rd_idx[ffpa_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else if (cmd.load) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else if (cmd.scan) begin
      if (rd_idx < entry_count) begin
        rd_idx  <= rd_idx + ffpa_pkg::CNT_W'(1);
        cmp_vld <= 1'b1;
      end else begin
        cmp_vld <= 1'b0;
      end
    end
  end

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_free  <= '0;
      entry_count <= '0;
    end else begin
      if (cmd.commit_hit) begin
        entry_free[cmp_idx] <= (op.action == ffpa_pkg::ACT_FREE);
      end else if (cmd.append && append_ok) begin
        entry_free[entry_count[ffpa_pkg::IDX_W-1:0]] <= 1'b0;
        entry_count <= entry_count + ffpa_pkg::CNT_W'(1);
      end
    end
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit_hit | cmd.fail_unknown | cmd.fail_room | cmd.append;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.commit_hit) begin
      result.status         <= ffpa_pkg::STAT_OK;
      result.payload_offset <= (op.action == ffpa_pkg::ACT_FREE) ? op.free_offset
                               : rd_data.off[ffpa_pkg::FIELD_W-1:0];
    end else if (cmd.fail_unknown) begin
      result.status         <= ffpa_pkg::STAT_UNKNOWN;
      result.payload_offset <= '0;
    end else if (cmd.fail_room) begin
      result.status         <= ffpa_pkg::STAT_NO_ROOM;
      result.payload_offset <= '0;
    end else if (cmd.append) begin
      result.status         <= append_ok ? ffpa_pkg::STAT_OK : ffpa_pkg::STAT_NO_ROOM;
      result.payload_offset <= append_ok ? payload[ffpa_pkg::FIELD_W-1:0] : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= ffpa_pkg::CNT_W'(ffpa_pkg::MAX_ENTRIES))
    else $error("chunk count beyond table depth");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.commit_hit | cmd.fail_unknown | cmd.fail_room | cmd.append))
    else $error("result strobe without a finishing command");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.append && append_ok) |=> (entry_count == $past(entry_count) + ffpa_pkg::CNT_W'(1)))
    else $error("append did not grow the table");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ffpa_pkg::STAT_OK)) |-> (result.payload_offset == '0))
    else $error("failed transaction carries a nonzero offset");

  a_hit_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_hit |-> cmp_vld)
    else $error("commit without a compared entry");

endmodule

`default_nettype wire

### hw/rtl/first_fit_pool_allocator.sv
// first_fit_pool_allocator: top level of the first-fit pool allocator
// depends on ffpa_pkg, ffpa_ctrl and ffpa_datapath
`default_nettype none

//  channel   handshake          payload        notes
//  request   start & !busy      req (req_t)    action, req_size, free_offset
//  result    done (1 cycle)     result (res_t) status, payload_offset
//
//  a transaction walks the table from entry 0 until a hit or exhaustion; an alloc that
//  exhausts a table with room then reads the last chunk and tries an append. the walk
//  is bounded by the single read port of the chunk table, walked one entry per cycle.
//  busy drops in the cycle the result is strobed, so the next request can be
//  accepted then. synchronous reset empties the table (count and free flags
//  cleared) and holds busy high; the result strobe cannot be stalled by the receiver

module first_fit_pool_allocator (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire ffpa_pkg::req_t req,
  output logic                done,
  output ffpa_pkg::res_t      result
);

  // command and status between sequencer and datapath
  ffpa_pkg::cmd_t  cmd;
  ffpa_pkg::stat_t stat;

  // sequencer: idle, pipelined table walk, tail check for append
  ffpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: chunk table memory, free flags, compare and append arithmetic
  ffpa_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

`default_nettype wire
